// ===== rtl/core/gcdl_pkg.sv =====
// ----------------------------------------------------------------------------
// gcdl_pkg: shared types and constants for the gcd / lcm unit
// Port widths, operation codes and the status bundle of the lcm engine.
// ----------------------------------------------------------------------------
`default_nettype none

package gcdl_pkg;

    // Fixed port widths of the operand and result fields
    localparam int OPERAND_W = 32;
    localparam int RESULT_W  = 64;

    // Operation codes carried by the kind field
    localparam logic KIND_GCD = 1'b0;
    localparam logic KIND_LCM = 1'b1;

    // Status of the serial divide / multiply engine
    typedef struct packed {
        logic busy;   // engine holds a job
        logic done;   // one-cycle pulse, product is valid
    } lcm_sts_t;

endpackage : gcdl_pkg

`default_nettype wire

// ===== rtl/core/gcdl_lcm_seq.sv =====
// ----------------------------------------------------------------------------
// gcdl_lcm_seq: bit-serial divide then multiply
// Computes (dividend / divisor) * mcand, one quotient bit per cycle in a
// restoring divider, then one multiplier bit per cycle in a shift-add loop.
// ----------------------------------------------------------------------------
`default_nettype none

module gcdl_lcm_seq
    import gcdl_pkg::*;
#(
    parameter int WIDTH = 32
)(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [WIDTH-1:0]   dividend,
    input  wire logic [WIDTH-1:0]   divisor,
    input  wire logic [WIDTH-1:0]   mcand,
    output logic [2*WIDTH-1:0]      product,
    output lcm_sts_t                sts
);

    localparam int CNT_W = $clog2(WIDTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [WIDTH-1:0]   rem_reg, rem_next;     // division remainder
    logic [WIDTH-1:0]   quo_reg, quo_next;     // dividend in, quotient out, low product
    logic [WIDTH-1:0]   dvs_reg, dvs_next;
    logic [WIDTH-1:0]   mcd_reg, mcd_next;
    logic [WIDTH:0]     hi_reg, hi_next;       // high half of the product
    logic               done_reg, done_next;

    logic [WIDTH:0]     shifted;
    logic [WIDTH:0]     trial;
    logic               ge;
    logic [WIDTH:0]     sum;
    logic               last;

    // One step of the restoring divider
    assign shifted = {rem_reg, quo_reg[WIDTH-1]};
    assign trial   = shifted - {1'b0, dvs_reg};
    assign ge      = ~trial[WIDTH];

    // One step of the shift-add multiplier
    assign sum  = quo_reg[0] ? (hi_reg + {1'b0, mcd_reg}) : hi_reg;
    assign last = (cnt_reg == CNT_W'(WIDTH - 1));

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dvs_next   = dvs_reg;
        mcd_next   = mcd_reg;
        hi_next    = hi_reg;
        done_next  = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    rem_next   = '0;
                    quo_next   = dividend;
                    dvs_next   = divisor;
                    mcd_next   = mcand;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next = ge ? trial[WIDTH-1:0] : shifted[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], ge};
                cnt_next = cnt_reg + CNT_W'(1);
                if (last)
                begin
                    cnt_next   = '0;
                    hi_next    = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                hi_next  = {1'b0, sum[WIDTH:1]};
                quo_next = {sum[0], quo_reg[WIDTH-1:1]};
                cnt_next = cnt_reg + CNT_W'(1);
                if (last)
                begin
                    cnt_next   = '0;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        mcd_reg <= mcd_next;
        hi_reg  <= hi_next;
    end

    assign product  = {hi_reg[WIDTH-1:0], quo_reg};
    assign sts.busy = (state_reg != ST_IDLE);
    assign sts.done = done_reg;

    // Jobs arrive only while the engine is free
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> state_reg == ST_IDLE)
        else $error("lcm engine started while busy");

    // The divisor is a gcd of nonzero operands, never zero
    a_dvs_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> dvs_reg != '0)
        else $error("divide by zero in lcm engine");

    // The gcd divides the dividend exactly
    a_exact_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL && cnt_reg == '0) |-> rem_reg == '0)
        else $error("nonzero remainder: gcd does not divide operand");

endmodule : gcdl_lcm_seq

`default_nettype wire

// ===== rtl/core/gcd_lcm_unit.sv =====
// ----------------------------------------------------------------------------
// gcd_lcm_unit: greatest common divisor / least common multiple
// Binary gcd with one shift or subtract per cycle; lcm as (a / g) * b
// through a bit-serial divider and shift-add multiplier.
// ----------------------------------------------------------------------------
//
//  channel | signals                          | beat content
//  --------+----------------------------------+------------------------------
//  in      | in_valid, in_ready               | kind, operand_a, operand_b
//  out     | out_valid, out_ready             | result
//
//  Steps: gcd loads the beat, runs one shift or subtract of the binary gcd
//  loop at a time, then shifts back once per shared factor of two and
//  emits. lcm adds a divide pass and a multiply pass through the
//  one-bit-per-cycle serial engine, then hands the product back.
//  One beat is in flight at a time; in_ready is high only while idle.
//  The result sits in an output register, so a stalled out channel holds
//  the finished beat while the next one is taken and worked on.
//  Reset clears the control state and the output register; no clearing pass.
//  Operand bits above WIDTH are ignored; gcd(0, x) = x, lcm with a zero is 0.
//
`default_nettype none

module gcd_lcm_unit
    import gcdl_pkg::*;
#(
    parameter int WIDTH = 32
)(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic                   kind,
    input  wire logic [OPERAND_W-1:0]   operand_a,
    input  wire logic [OPERAND_W-1:0]   operand_b,

    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [RESULT_W-1:0]         result
);

    localparam int K_W = $clog2(WIDTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GCD,     // binary gcd steps
        ST_SHIFT,   // restore the common power of two
        ST_LCM,     // wait for divide / multiply engine
        ST_EMIT     // hand the value to the output register
    } state_t;

    state_t                 state_reg, state_next;
    logic [WIDTH-1:0]       a_reg, a_next;       // ends up holding the gcd
    logic [WIDTH-1:0]       b_reg, b_next;
    logic [WIDTH-1:0]       opa_reg, opa_next;   // operands kept for lcm
    logic [WIDTH-1:0]       opb_reg, opb_next;
    logic                   kind_reg, kind_next;
    logic [K_W-1:0]         k_reg, k_next;       // shared factors of two
    logic [2*WIDTH-1:0]     pend_reg, pend_next;
    logic [2*WIDTH-1:0]     result_reg, result_next;
    logic                   ovalid_reg, ovalid_next;

    logic [WIDTH:0]         diff;
    logic [WIDTH-1:0]       ndiff;
    logic                   lcm_start;
    logic [2*WIDTH-1:0]     lcm_product;
    lcm_sts_t               lcm_sts;

    // a - b; the borrow tells which one is larger
    assign diff  = {1'b0, a_reg} - {1'b0, b_reg};
    assign ndiff = b_reg - a_reg;

    gcdl_lcm_seq #(
        .WIDTH      (WIDTH)
    ) u_lcm_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (lcm_start),
        .dividend   (opa_reg),
        .divisor    (a_reg),
        .mcand      (opb_reg),
        .product    (lcm_product),
        .sts        (lcm_sts)
    );

    always_comb
    begin
        state_next  = state_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        opa_next    = opa_reg;
        opb_next    = opb_reg;
        kind_next   = kind_reg;
        k_next      = k_reg;
        pend_next   = pend_reg;
        result_next = result_reg;
        ovalid_next = ovalid_reg;
        lcm_start   = 1'b0;

        // output beat taken
        if (ovalid_reg && out_ready)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    a_next     = operand_a[WIDTH-1:0];
                    b_next     = operand_b[WIDTH-1:0];
                    opa_next   = operand_a[WIDTH-1:0];
                    opb_next   = operand_b[WIDTH-1:0];
                    kind_next  = kind;
                    k_next     = '0;
                    state_next = ST_GCD;
                end
            end
            ST_GCD:
            begin
                if (a_reg == '0)
                begin
                    // gcd(0, b) = b
                    a_next     = b_reg;
                    state_next = ST_SHIFT;
                end
                else if (b_reg == '0 || a_reg == b_reg)
                begin
                    state_next = ST_SHIFT;
                end
                else if (!a_reg[0] && !b_reg[0])
                begin
                    a_next = a_reg >> 1;
                    b_next = b_reg >> 1;
                    k_next = k_reg + K_W'(1);
                end
                else if (!a_reg[0])
                begin
                    a_next = a_reg >> 1;
                end
                else if (!b_reg[0])
                begin
                    b_next = b_reg >> 1;
                end
                else if (!diff[WIDTH])
                begin
                    a_next = diff[WIDTH-1:0];
                end
                else
                begin
                    b_next = ndiff;
                end
            end
            ST_SHIFT:
            begin
                if (k_reg != '0)
                begin
                    a_next = a_reg << 1;
                    k_next = k_reg - K_W'(1);
                end
                else if (kind_reg == KIND_GCD)
                begin
                    pend_next  = (2*WIDTH)'(a_reg);
                    state_next = ST_EMIT;
                end
                else if (opa_reg == '0 || opb_reg == '0)
                begin
                    pend_next  = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    lcm_start  = 1'b1;
                    state_next = ST_LCM;
                end
            end
            ST_LCM:
            begin
                if (lcm_sts.done)
                begin
                    pend_next  = lcm_product;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                // wait for the output register to free up
                if (!ovalid_reg || out_ready)
                begin
                    result_next = pend_reg;
                    ovalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        opa_reg    <= opa_next;
        opb_reg    <= opb_next;
        kind_reg   <= kind_next;
        k_reg      <= k_next;
        pend_reg   <= pend_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = ovalid_reg;
    assign result    = RESULT_W'(result_reg);

    // Engine completes only while the controller is waiting on it
    a_done_in_lcm: assert property (@(posedge clk) disable iff (!rst_n)
        lcm_sts.done |-> state_reg == ST_LCM)
        else $error("lcm engine done outside wait state");

    // Engine is free while a new gcd runs
    a_idle_engine: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_GCD |-> !lcm_sts.busy)
        else $error("lcm engine busy during gcd");

    // gcd of two nonzero operands is nonzero
    a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT && opa_reg != '0 && opb_reg != '0) |-> a_reg != '0)
        else $error("zero gcd from nonzero operands");

    // Taking a new beat does not disturb the waiting result
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> $stable(result_reg))
        else $error("result changed on input beat");

endmodule : gcd_lcm_unit

`default_nettype wire
